// ===== rtl/gwl_pkg.sv =====
// Shared types, constants and the fixed-point log2 table for the greyscale window lookup.
// No dependencies; every other file in rtl imports this package.
package gwl_pkg;

	localparam int LOG_FRAC_BITS = 16;
	localparam int PIX_W         = 8;
	localparam int LOG_W         = LOG_FRAC_BITS + 3;
	localparam int NUM_W         = LOG_W + PIX_W;
	localparam int DEN_W         = LOG_W;
	localparam int Q_W           = PIX_W + 1;
	localparam int NST           = Q_W + 1;
	localparam int GREY_MAX      = 255;
	localparam int MANT_FRAC     = 30;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = 2;
	localparam int TAB_N         = 1 << PIX_W;

	typedef enum logic [1:0] {K_BLACK, K_WHITE, K_DIV} kind_t;
	typedef enum logic [1:0] {REG_LOW, REG_HIGH, REG_LOG, REG_MASK} cfg_reg_t;

	typedef struct packed {
		kind_t              kind;
		logic [NUM_W-1:0]   num;
		logic [DEN_W-1:0]   den;
		logic               rainbow;
		logic               above;
	} work_t;

	typedef logic [LOG_W-1:0] log_tab_t [TAB_N];

	function automatic log_tab_t build_log_tab();
		log_tab_t          tab;
		longint unsigned   m;
		int                n;
		logic [LOG_W-1:0]  res;
		for (int x = 0; x < TAB_N; x++) begin
			n = 0;
			for (int k = 1; k < PIX_W; k++) begin
				if ((x >> k) != 0) n = k;
			end
			m = longint'(x) << (MANT_FRAC - n);
			res = LOG_W'(n) << LOG_FRAC_BITS;
			for (int b = LOG_FRAC_BITS - 1; b >= 0; b--) begin
				m = (m * m) >> MANT_FRAC;
				if (m >= (64'd2 << MANT_FRAC)) begin
					res[b] = 1'b1;
					m = m >> 1;
				end
			end
			tab[x] = (x == 0) ? '0 : res;
		end
		return tab;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ===== rtl/greyscale_window_lut_top.sv =====
// Top level of the window/level greyscale lookup: front end, request queue, divider back end.
// Depends on gwl_pkg, gwl_front, gwl_fifo, gwl_back.
//
//  channel  | signals                              | payload
//  cfg      | cfg_valid, cfg_ready                 | cfg_index, cfg_data
//  s_axis   | s_axis_tvalid, s_axis_tready         | tdata[7:0] pixel_code
//  m_axis   | m_axis_tvalid, m_axis_tready         | tdata grey_rgb, tuser rainbow/above
//
// One pixel per clock sustained while m_axis_tready is high; path: front register, queue, 10 divider stages.
// After its load stage the divider takes one quotient bit per stage, so its depth sets the latency.
// cfg_ready is always high; no clearing pass after reset.
// Output stalls back up through the divider into the queue; the front keeps accepting
// until the four-entry queue and the front register are full.
module greyscale_window_lut_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_code
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [23:0] grey_rgb
	output logic [1:0]  m_axis_tuser    // [0] rainbow_selected, [1] above_mask
);
	import gwl_pkg::*;

	work_t fw_data, bw_data;
	logic  fw_valid, fw_ready, bw_valid, bw_ready;

	gwl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.work_valid(fw_valid), .work_ready(fw_ready), .work_data(fw_data)
	);

	gwl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw_data),
		.out_valid(bw_valid), .out_ready(bw_ready), .out_data(bw_data)
	);

	gwl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(bw_valid), .in_ready(bw_ready), .in_data(bw_data),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

endmodule

// ===== rtl/gwl_front.sv =====
// Front end: configuration registers, pixel classification and stretch operands.
// Depends on gwl_pkg (types, log2 table).
module gwl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [7:0]                  cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,
	output logic                        work_valid,
	input  logic                        work_ready,
	output gwl_pkg::work_t              work_data
);
	import gwl_pkg::*;

	logic [PIX_W-1:0] low_q, high_q, mask_q;
	logic             log_q;
	logic [PIX_W-1:0] mask, lo_s, hi_s, lo_c, pix, dp, dw;
	logic [LOG_W-1:0] l_p, l_w;
	work_t            work;
	work_t            work_s1;
	logic             valid_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			log_q  <= 1'b0;
			mask_q <= PIX_W'(GREY_MAX);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOW:  low_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				REG_LOG:  log_q  <= cfg_data[0];
				REG_MASK: mask_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_comb begin
		pix  = s_axis_tdata;
		mask = (mask_q == '0) ? PIX_W'(1) : mask_q;
		lo_s = (low_q > high_q) ? high_q : low_q;
		hi_s = (low_q > high_q) ? low_q : high_q;
		lo_c = (lo_s > mask) ? mask : lo_s;
		dp   = pix - lo_c;
		dw   = hi_s - lo_c;
		l_p  = LOG_TAB[dp];
		l_w  = LOG_TAB[dw];
		work.kind    = K_BLACK;
		work.num     = '0;
		work.den     = '0;
		work.rainbow = (low_q == '0) && (high_q == '0);
		work.above   = pix > mask;
		if (work.rainbow) begin
			work.kind = K_BLACK;
		end else if (work.above) begin
			work.kind = K_WHITE;
		end else if (pix < lo_c) begin
			work.kind = K_BLACK;
		end else if (pix < hi_s) begin
			if (log_q) begin
				if (l_w != '0) begin
					work.kind = K_DIV;
					work.num  = {l_p, PIX_W'(0)} - NUM_W'(l_p);
					work.den  = l_w;
				end
			end else begin
				work.kind = K_DIV;
				work.num  = NUM_W'({dp, PIX_W'(0)}) - NUM_W'(dp);
				work.den  = DEN_W'(dw);
			end
		end else begin
			work.kind = K_WHITE;
		end
	end

	assign s_axis_tready = !valid_s1 || work_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			work_s1 <= work;
		end
	end

	assign work_valid = valid_s1;
	assign work_data  = work_s1;

endmodule

// ===== rtl/gwl_fifo.sv =====
// Short request queue between the classifying front end and the divider back end.
// Depends on gwl_pkg (work_t, depth constants).
module gwl_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gwl_pkg::work_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output gwl_pkg::work_t  out_data
);
	import gwl_pkg::*;

	work_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               push, pop;

	assign in_ready  = count_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = mem[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)      count_q <= count_q + (FIFO_AW+1)'(1);
			else if (pop && !push) count_q <= count_q - (FIFO_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= in_data;
	end

endmodule

// ===== rtl/gwl_back.sv =====
// Back end: pipelined restoring divider; one quotient bit per stage after the load.
// Depends on gwl_pkg (work_t, widths).
module gwl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gwl_pkg::work_t  in_data,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [23:0]     m_axis_tdata,
	output logic [1:0]      m_axis_tuser
);
	import gwl_pkg::*;

	logic               v_s       [1:NST];
	kind_t              kind_s    [1:NST];
	logic [NUM_W-1:0]   rem_s     [1:NST];
	logic [DEN_W-1:0]   den_s     [1:NST];
	logic [Q_W-1:0]     quo_s     [1:NST];
	logic               rainbow_s [1:NST];
	logic               above_s   [1:NST];
	logic [NUM_W:0]     trial     [2:NST];
	logic               adv;
	logic [PIX_W-1:0]   grey;

	assign adv      = !v_s[NST] || m_axis_tready;
	assign in_ready = adv;

	always_comb begin
		for (int i = 2; i <= NST; i++) begin
			trial[i] = {1'b0, rem_s[i-1]} - ({1'b0, NUM_W'(den_s[i-1])} << (NST - i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= in_valid;
			for (int i = 2; i <= NST; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s[1]    <= in_data.kind;
			rem_s[1]     <= in_data.num;
			den_s[1]     <= in_data.den;
			quo_s[1]     <= '0;
			rainbow_s[1] <= in_data.rainbow;
			above_s[1]   <= in_data.above;
			for (int i = 2; i <= NST; i++) begin
				kind_s[i]    <= kind_s[i-1];
				den_s[i]     <= den_s[i-1];
				rainbow_s[i] <= rainbow_s[i-1];
				above_s[i]   <= above_s[i-1];
				quo_s[i]     <= quo_s[i-1];
				rem_s[i]     <= rem_s[i-1];
				if (!trial[i][NUM_W]) begin
					quo_s[i][NST-i] <= 1'b1;
					rem_s[i]        <= trial[i][NUM_W-1:0];
				end
			end
		end
	end

	always_comb begin
		case (kind_s[NST])
			K_BLACK: grey = '0;
			K_WHITE: grey = PIX_W'(GREY_MAX);
			K_DIV:   grey = quo_s[NST][Q_W-1] ? PIX_W'(GREY_MAX) : quo_s[NST][PIX_W-1:0];
			default: grey = '0;
		endcase
	end

	assign m_axis_tvalid = v_s[NST];
	assign m_axis_tdata  = {grey, grey, grey};
	assign m_axis_tuser  = {above_s[NST], rainbow_s[NST]};

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[1] && kind_s[1] == K_DIV |-> den_s[1] != '0)
		else $error("stretch request with zero divisor");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NST] && kind_s[NST] == K_DIV |-> rem_s[NST] < NUM_W'(den_s[NST]))
		else $error("divider remainder not reduced");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NST] && kind_s[NST] == K_DIV |-> quo_s[NST] <= Q_W'(GREY_MAX))
		else $error("stretch quotient above full scale");

endmodule
